// ===== src/btoe_pkg.sv =====
// Package: shared constants and types for the offset-escape text encoder.
package btoe_pkg;

    localparam int unsigned MAX_BLOCK_BYTES = 65535;
    localparam int unsigned HIST_DEPTH      = 256;
    localparam int unsigned HIST_AW         = $clog2(HIST_DEPTH);
    localparam int unsigned HIST_W          = 16;
    localparam int unsigned SUM_W           = HIST_W + 2;

    localparam logic [HIST_W-1:0] HIST_MAX  = '1;
    localparam logic [HIST_W-1:0] BLOCK_CAP =
        HIST_W'((MAX_BLOCK_BYTES > 65535) ? 65535 : MAX_BLOCK_BYTES);

    localparam logic [7:0] QUOTE_BYTE = 8'h27;
    localparam logic [7:0] EMPTY_MARK = 8'h78;
    localparam logic [7:0] ESC_BYTE   = 8'h01;
    localparam logic [7:0] ESC_ZERO   = 8'h01;
    localparam logic [7:0] ESC_ONE    = 8'h02;
    localparam logic [7:0] ESC_QUOTE  = 8'h03;
    localparam logic [7:0] TERM_BYTE  = 8'h00;

    typedef enum logic [1:0] {
        REQ_COUNT  = 2'd0,
        REQ_CHOOSE = 2'd1,
        REQ_ENCODE = 2'd2,
        REQ_END    = 2'd3
    } req_t;

    typedef struct packed {
        logic               we;
        logic               clr;
        logic [HIST_AW-1:0] waddr;
        logic [HIST_W-1:0]  wdata;
        logic [HIST_AW-1:0] raddr;
    } hist_ctl_t;

endpackage

// ===== src/btoe_hist_mem.sv =====
// Histogram store: 256 x 16 memory with per-entry valid bits that a clear resets together.
module btoe_hist_mem
    import btoe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  hist_ctl_t         ctl,
    output logic [HIST_W-1:0] rd_data
);

    logic [HIST_W-1:0]     mem [HIST_DEPTH];
    logic [HIST_W-1:0]     mem_q_reg;
    logic [HIST_DEPTH-1:0] valid_reg;
    logic                  rvld_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        mem_q_reg <= mem[ctl.raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rvld_reg  <= 1'b0;
        end else begin
            rvld_reg <= valid_reg[ctl.raddr];
            if (ctl.clr) begin
                valid_reg <= '0;
            end else if (ctl.we) begin
                valid_reg[ctl.waddr] <= 1'b1;
            end
        end
    end

    // entries not written since the last clear read as zero
    assign rd_data = rvld_reg ? mem_q_reg : '0;

endmodule

// ===== src/binary_to_text_offset_encoder.sv =====
// Offset-escape binary-to-text encoder: top level with request sequencer.
//
// Requests come in on s_ (tuser = request kind, tdata = byte); text bytes leave on m_,
// m_tlast marking the zero terminator. One request is handled at a time. A count
// is a read-modify-write of the histogram memory; when the block is already full
// the byte is dropped. A choose runs the offset search over one histogram read
// port over up to 254 candidate offsets, stopping early when a zero-count
// candidate turns up; an empty block answers without a search. Encode and end
// requests hand each result byte to the output register in turn.
// A cycle that hands a byte to the output register waits while the previous byte
// there is not yet taken by m_tready. The end request clears the histogram when
// it is accepted.
module binary_to_text_offset_encoder
    import btoe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT,
        S_SRCH,
        S_EMIT,
        S_EMIT2
    } state_t;

    state_t            state_reg, state_next;
    logic [HIST_W-1:0] total_reg, total_next;
    logic [7:0]        offset_reg, offset_next;
    logic [7:0]        cnt_addr_reg, cnt_addr_next;
    logic [7:0]        v_reg, v_next;
    logic [1:0]        ph_reg, ph_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [SUM_W-1:0]  best_reg, best_next;
    logic [7:0]        pick_reg, pick_next;
    logic [7:0]        pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              esc_reg, esc_next;
    logic [7:0]        esc_byte_reg, esc_byte_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    hist_ctl_t         hctl;
    logic [HIST_W-1:0] hist_rd;
    logic [SUM_W-1:0]  sum;
    logic [7:0]        enc;
    logic              out_free;
    logic              accept;
    logic              better;

    btoe_hist_mem u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (hctl),
        .rd_data (hist_rd)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign sum      = acc_reg + SUM_W'(hist_rd);
    assign better   = (sum < best_reg);
    assign enc      = s_tdata - offset_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        state_next     = state_reg;
        total_next     = total_reg;
        offset_next    = offset_reg;
        cnt_addr_next  = cnt_addr_reg;
        v_next         = v_reg;
        ph_next        = ph_reg;
        acc_next       = acc_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        esc_next       = esc_reg;
        esc_byte_next  = esc_byte_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        hctl.we    = 1'b0;
        hctl.clr   = 1'b0;
        hctl.waddr = cnt_addr_reg;
        hctl.wdata = (hist_rd == HIST_MAX) ? hist_rd : hist_rd + HIST_W'(1);
        hctl.raddr = s_tdata;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    pend_last_next = 1'b0;
                    esc_next       = 1'b0;
                    case (req_t'(s_tuser))
                        REQ_COUNT: begin
                            if (total_reg < BLOCK_CAP) begin
                                total_next    = total_reg + HIST_W'(1);
                                cnt_addr_next = s_tdata;
                                state_next    = S_CNT;
                            end
                        end
                        REQ_CHOOSE: begin
                            if (total_reg == '0) begin
                                offset_next = EMPTY_MARK;
                                pend_next   = EMPTY_MARK;
                                state_next  = S_EMIT;
                            end else begin
                                v_next     = 8'd1;
                                ph_next    = 2'd0;
                                best_next  = '1;
                                pick_next  = 8'd1;
                                state_next = S_SRCH;
                            end
                        end
                        REQ_ENCODE: begin
                            state_next = S_EMIT;
                            if (enc == 8'd0) begin
                                pend_next     = ESC_BYTE;
                                esc_next      = 1'b1;
                                esc_byte_next = ESC_ZERO;
                            end else if (enc == 8'd1) begin
                                pend_next     = ESC_BYTE;
                                esc_next      = 1'b1;
                                esc_byte_next = ESC_ONE;
                            end else if (enc == QUOTE_BYTE) begin
                                pend_next     = ESC_BYTE;
                                esc_next      = 1'b1;
                                esc_byte_next = ESC_QUOTE;
                            end else begin
                                pend_next = enc;
                            end
                        end
                        REQ_END: begin
                            hctl.clr       = 1'b1;
                            total_next     = '0;
                            pend_next      = TERM_BYTE;
                            pend_last_next = 1'b1;
                            state_next     = S_EMIT;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CNT: begin
                hctl.we    = 1'b1;
                state_next = S_IDLE;
            end
            S_SRCH: begin
                ph_next = ph_reg + 2'd1;
                case (ph_reg)
                    2'd0: hctl.raddr = v_reg;
                    2'd1: hctl.raddr = v_reg + 8'd1;
                    2'd2: hctl.raddr = v_reg + QUOTE_BYTE;
                    default: hctl.raddr = v_reg;
                endcase
                case (ph_reg)
                    2'd1: acc_next = SUM_W'(hist_rd);
                    2'd2: acc_next = sum;
                    2'd3: begin
                        if (better) begin
                            best_next = sum;
                            pick_next = v_reg;
                        end
                        if (v_reg == 8'hFF || (better && sum == '0)) begin
                            offset_next = better ? v_reg : pick_reg;
                            pend_next   = better ? v_reg : pick_reg;
                            state_next  = S_EMIT;
                        end else if (v_reg + 8'd1 == QUOTE_BYTE) begin
                            v_next = v_reg + 8'd2;
                        end else begin
                            v_next = v_reg + 8'd1;
                        end
                    end
                    default: begin
                        acc_next = acc_reg;
                    end
                endcase
            end
            S_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pend_reg;
                    out_last_next  = pend_last_reg;
                    state_next     = esc_reg ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = esc_byte_reg;
                    out_last_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
        end
        cnt_addr_reg  <= cnt_addr_next;
        v_reg         <= v_next;
        ph_reg        <= ph_next;
        acc_reg       <= acc_next;
        best_reg      <= best_next;
        pick_reg      <= pick_next;
        pend_reg      <= pend_next;
        pend_last_reg <= pend_last_next;
        esc_reg       <= esc_next;
        esc_byte_reg  <= esc_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

endmodule
